// File: hw/rtl/assert_macros.svh
// Assertion helpers included by the codec core RTL.
// Each macro takes a label, clock, reset, antecedent, consequent and message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/crc8rfc_pkg.sv
// ----------------------------------------------------------------------------
// CRC-8 register frame codec package
// Opcodes, result kinds, frame constants and the byte-wide CRC-8 update.
// ----------------------------------------------------------------------------
`default_nettype none

package crc8rfc_pkg;

   localparam logic [7:0] CRC_POLY = 8'h07;
   localparam logic [7:0] CRC_INIT = 8'h00;

   // Reply frame: address echo, four value bytes, CRC byte
   localparam int unsigned REPLY_LEN = 6;
   localparam logic [2:0] REPLY_LAST_IDX = 3'(REPLY_LEN - 1);

   // Data bytes ahead of the CRC in a write and a read request
   localparam logic [2:0] WRITE_DATA_BYTES = 3'd5;
   localparam logic [2:0] READ_DATA_BYTES  = 3'd1;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_REPLY = 2'd2;

   localparam logic KIND_TX     = 1'b0;
   localparam logic KIND_DECODE = 1'b1;

   // One byte through the CRC, MSB first
   function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                              input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/crc8rfc_if.sv
// ----------------------------------------------------------------------------
// CRC-8 register frame codec channels
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
`default_nettype none

interface crc8rfc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [7:0]  reg_address;
   logic [31:0] write_value;
   logic [7:0]  rx_byte;

   modport source (output valid, opcode, reg_address, write_value, rx_byte,
                   input ready);
   modport sink   (input valid, opcode, reg_address, write_value, rx_byte,
                   output ready);
endinterface

interface crc8rfc_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [7:0]  tx_byte;
   logic        frame_last;
   logic [31:0] read_value;
   logic        crc_ok;

   modport source (output valid, result_kind, tx_byte, frame_last, read_value, crc_ok,
                   input ready);
   modport sink   (input valid, result_kind, tx_byte, frame_last, read_value, crc_ok,
                   output ready);
endinterface

`default_nettype wire

// File: hw/rtl/crc8_register_frame_codec_core.sv
// A request is first loaded into the pending frame registers; its first result then
// moves into the response register once that register is empty or being read.
// One result per cycle leaves the single response register while the response side is
// ready; a write request yields 6 results, a read request 2, and only a reply's closing byte 1.
// Reset (synchronous, active high) empties the frame and response registers and
// clears the reply byte count, CRC and value to zero.
// ----------------------------------------------------------------------------
// CRC-8 register frame codec core
// Serialises write and read request frames and decodes six-byte replies.
// The running CRC of an outgoing frame advances one byte per emitted data byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module crc8_register_frame_codec_core
   import crc8rfc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   crc8rfc_req_if.sink   req_port,
   crc8rfc_rsp_if.source rsp_port
);

   // Reply receive state
   logic [2:0]  reply_count_ff, reply_count_in;
   logic [7:0]  reply_crc_ff,   reply_crc_in;
   logic [31:0] reply_value_ff, reply_value_in;

   // Pending transaction being serialised into results
   logic        pend_ff,        pend_in;
   logic        pend_decode_ff, pend_decode_in;
   logic [39:0] shift_ff,       shift_in;
   logic [2:0]  left_ff,        left_in;
   logic [7:0]  crc_ff,         crc_in;
   logic [31:0] dec_value_ff,   dec_value_in;
   logic        dec_ok_ff,      dec_ok_in;

   // Response register
   logic        out_valid_ff,   out_valid_in;
   logic        out_kind_ff,    out_kind_in;
   logic [7:0]  out_tx_ff,      out_tx_in;
   logic        out_last_ff,    out_last_in;
   logic [31:0] out_value_ff,   out_value_in;
   logic        out_ok_ff,      out_ok_in;

   logic accept;
   logic emit;
   logic pend_last;
   logic reply_done;

   assign emit       = pend_ff && (!out_valid_ff || rsp_port.ready);
   assign pend_last  = pend_decode_ff || (left_ff == 3'd0);
   assign req_port.ready = !pend_ff || (emit && pend_last);
   assign accept     = req_port.valid && req_port.ready;
   assign reply_done = (reply_count_ff >= REPLY_LAST_IDX);

   always_comb begin
      reply_count_in = reply_count_ff;
      reply_crc_in   = reply_crc_ff;
      reply_value_in = reply_value_ff;
      if (accept && req_port.opcode == OP_REPLY) begin
         if (reply_done) begin
            reply_count_in = 3'd0;
            reply_crc_in   = CRC_INIT;
            reply_value_in = '0;
         end else begin
            reply_crc_in   = crc8_update(reply_crc_ff, req_port.rx_byte);
            // the address echo is covered by the CRC but not the value
            if (reply_count_ff != 3'd0) begin
               reply_value_in = {reply_value_ff[23:0], req_port.rx_byte};
            end
            reply_count_in = reply_count_ff + 3'd1;
         end
      end
   end

   always_comb begin
      pend_in        = pend_ff;
      pend_decode_in = pend_decode_ff;
      shift_in       = shift_ff;
      left_in        = left_ff;
      crc_in         = crc_ff;
      dec_value_in   = dec_value_ff;
      dec_ok_in      = dec_ok_ff;

      out_valid_in   = out_valid_ff && !rsp_port.ready;
      out_kind_in    = out_kind_ff;
      out_tx_in      = out_tx_ff;
      out_last_in    = out_last_ff;
      out_value_in   = out_value_ff;
      out_ok_in      = out_ok_ff;

      // advance the pending transaction by one result
      if (emit) begin
         out_valid_in = 1'b1;
         if (pend_decode_ff) begin
            out_kind_in  = KIND_DECODE;
            out_tx_in    = '0;
            out_last_in  = 1'b0;
            out_value_in = dec_value_ff;
            out_ok_in    = dec_ok_ff;
         end else if (left_ff != 3'd0) begin
            out_kind_in  = KIND_TX;
            out_tx_in    = shift_ff[39:32];
            out_last_in  = 1'b0;
            out_value_in = '0;
            out_ok_in    = 1'b0;
            crc_in       = crc8_update(crc_ff, shift_ff[39:32]);
            shift_in     = {shift_ff[31:0], 8'h00};
            left_in      = left_ff - 3'd1;
         end else begin
            out_kind_in  = KIND_TX;
            out_tx_in    = crc_ff;
            out_last_in  = 1'b1;
            out_value_in = '0;
            out_ok_in    = 1'b0;
         end
         if (pend_last) begin
            pend_in = 1'b0;
         end
      end

      if (accept) begin
         case (req_port.opcode)
            OP_WRITE: begin
               pend_in        = 1'b1;
               pend_decode_in = 1'b0;
               shift_in       = {req_port.reg_address, req_port.write_value};
               left_in        = WRITE_DATA_BYTES;
               crc_in         = CRC_INIT;
            end
            OP_READ: begin
               pend_in        = 1'b1;
               pend_decode_in = 1'b0;
               shift_in       = {req_port.reg_address, 32'h0};
               left_in        = READ_DATA_BYTES;
               crc_in         = CRC_INIT;
            end
            OP_REPLY: begin
               // only the closing byte of a reply yields a result
               if (reply_done) begin
                  pend_in        = 1'b1;
                  pend_decode_in = 1'b1;
                  dec_value_in   = reply_value_ff;
                  dec_ok_in      = (req_port.rx_byte == reply_crc_ff);
               end
            end
            default: begin
               // unused opcode: drop the transaction
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reply_count_ff <= 3'd0;
         reply_crc_ff   <= CRC_INIT;
         reply_value_ff <= '0;
         pend_ff        <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         reply_count_ff <= reply_count_in;
         reply_crc_ff   <= reply_crc_in;
         reply_value_ff <= reply_value_in;
         pend_ff        <= pend_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_decode_ff <= pend_decode_in;
      shift_ff       <= shift_in;
      left_ff        <= left_in;
      crc_ff         <= crc_in;
      dec_value_ff   <= dec_value_in;
      dec_ok_ff      <= dec_ok_in;
      out_kind_ff    <= out_kind_in;
      out_tx_ff      <= out_tx_in;
      out_last_ff    <= out_last_in;
      out_value_ff   <= out_value_in;
      out_ok_ff      <= out_ok_in;
   end

   assign rsp_port.valid       = out_valid_ff;
   assign rsp_port.result_kind = out_kind_ff;
   assign rsp_port.tx_byte     = out_tx_ff;
   assign rsp_port.frame_last  = out_last_ff;
   assign rsp_port.read_value  = out_value_ff;
   assign rsp_port.crc_ok      = out_ok_ff;

   `ASSERT_SAME(a_reply_count_range, clock, reset, 1'b1,
                reply_count_ff <= REPLY_LAST_IDX, "reply count past frame end")
   `ASSERT_SAME(a_accept_only_on_last, clock, reset, accept && pend_ff,
                emit && pend_last, "request taken while frame still pending")
   `ASSERT_NEXT(a_write_loads_frame, clock, reset, accept && req_port.opcode == OP_WRITE,
                pend_ff && !pend_decode_ff && left_ff == WRITE_DATA_BYTES,
                "write request not loaded")
   `ASSERT_SAME(a_decode_fields_clear, clock, reset,
                out_valid_ff && out_kind_ff == KIND_DECODE,
                out_tx_ff == 8'h00 && !out_last_ff, "decode result carries frame byte fields")

endmodule

`default_nettype wire

// File: test/tb_crc8_register_frame_codec_core.sv
// ----------------------------------------------------------------------------
// CRC-8 register frame codec testbench
// Drives write, read, reply-byte and unused-opcode transactions with random gaps on the
// request side and random stalls on the response side. Every accepted request
// is run through a local model of the framing and reply decode, and each
// response is compared field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_crc8_register_frame_codec_core
   import crc8rfc_pkg::*;
;

   localparam logic [1:0]  OP_UNUSED    = 2'd3;
   localparam int unsigned RANDOM_ITEMS = 430;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam int unsigned N_DIRECTED   = 23;

   typedef struct packed {
      logic        kind;
      logic [7:0]  tx;
      logic        last;
      logic [31:0] value;
      logic        ok;
   } codec_result_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [7:0]       addr;
      logic [31:0]      wdata;
      logic [7:0]       rx;
      logic             pinned;
      codec_result_type pin;
   } stim_row_type;

   localparam codec_result_type NO_PIN = '0;

   logic clock;
   logic reset;

   crc8rfc_req_if req_bus ();
   crc8rfc_rsp_if rsp_bus ();

   crc8_register_frame_codec_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus.sink),
      .rsp_port (rsp_bus.source)
   );

   // Pinned rows carry the final response of the transaction, typed in by hand
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{OP_READ,   8'h00, 32'h0000_0000, 8'h00, 1'b1, '{KIND_TX, 8'h00, 1'b1, 32'h0, 1'b0}},
      '{OP_READ,   8'h01, 32'hFFFF_FFFF, 8'hFF, 1'b1, '{KIND_TX, 8'h07, 1'b1, 32'h0, 1'b0}},
      '{OP_READ,   8'hFF, 32'h0000_0000, 8'h00, 1'b1, '{KIND_TX, 8'hF3, 1'b1, 32'h0, 1'b0}},
      '{OP_READ,   8'h80, 32'h0000_0000, 8'h00, 1'b1, '{KIND_TX, 8'h89, 1'b1, 32'h0, 1'b0}},
      '{OP_WRITE,  8'h00, 32'h0000_0000, 8'hFF, 1'b1, '{KIND_TX, 8'h00, 1'b1, 32'h0, 1'b0}},
      '{OP_WRITE,  8'hFF, 32'hFFFF_FFFF, 8'h00, 1'b0, NO_PIN},
      '{OP_WRITE,  8'h5A, 32'h8000_0001, 8'h3C, 1'b0, NO_PIN},
      '{OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 1'b0, NO_PIN},
      '{OP_REPLY,  8'h00, 32'h0000_0000, 8'h00, 1'b0, NO_PIN},
      '{OP_REPLY,  8'h00, 32'h0000_0000, 8'h00, 1'b0, NO_PIN},
      '{OP_REPLY,  8'h00, 32'h0000_0000, 8'h00, 1'b0, NO_PIN},
      '{OP_REPLY,  8'h00, 32'h0000_0000, 8'h00, 1'b0, NO_PIN},
      '{OP_REPLY,  8'h00, 32'h0000_0000, 8'h00, 1'b0, NO_PIN},
      '{OP_REPLY,  8'h00, 32'h0000_0000, 8'h00, 1'b1,
        '{KIND_DECODE, 8'h00, 1'b0, 32'h0000_0000, 1'b1}},
      '{OP_REPLY,  8'hFF, 32'hFFFF_FFFF, 8'h12, 1'b0, NO_PIN},
      '{OP_REPLY,  8'h00, 32'h0000_0000, 8'hFF, 1'b0, NO_PIN},
      '{OP_REPLY,  8'h00, 32'h0000_0000, 8'h00, 1'b0, NO_PIN},
      // requests and an unused opcode in the middle of a reply
      '{OP_WRITE,  8'h33, 32'h0123_4567, 8'hAA, 1'b0, NO_PIN},
      '{OP_READ,   8'hC3, 32'h89AB_CDEF, 8'h55, 1'b0, NO_PIN},
      '{OP_UNUSED, 8'h00, 32'h0000_0000, 8'h00, 1'b0, NO_PIN},
      '{OP_REPLY,  8'h00, 32'h0000_0000, 8'h80, 1'b0, NO_PIN},
      '{OP_REPLY,  8'h00, 32'h0000_0000, 8'h01, 1'b0, NO_PIN},
      '{OP_REPLY,  8'h00, 32'h0000_0000, 8'hFF, 1'b0, NO_PIN}
   };

   codec_result_type results_due [$];
   logic [2:0]       reply_seen;
   logic [7:0]       reply_sum;
   logic [31:0]      reply_word;

   logic             row_pinned;
   codec_result_type row_pin;

   int unsigned   mismatches;
   int unsigned   items_sent;
   int unsigned   cycle_count;
   bit            req_calm;
   bit            rsp_calm;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
      logic [7:0] r;
      r = acc ^ data;
      for (int i = 0; i < 8; i++) begin
         r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
      end
      return r;
   endfunction

   function automatic codec_result_type tx_result(input logic [7:0] b, input logic last);
      codec_result_type r;
      r = '{KIND_TX, b, last, 32'h0, 1'b0};
      return r;
   endfunction

   // Mostly short gaps, a few long ones, none at all in a calm stretch
   function automatic int unsigned draw_gap(input bit calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // Frame bytes of a request, or the decode that a closing reply byte completes
   task automatic compute_codec_results(input logic [1:0] op, input logic [7:0] addr,
                                        input logic [31:0] wdata, input logic [7:0] rx);
      logic [7:0]       frame [5];
      logic [7:0]       acc;
      codec_result_type r;
      case (op)
         OP_WRITE: begin
            frame = '{addr, wdata[31:24], wdata[23:16], wdata[15:8], wdata[7:0]};
            acc = CRC_INIT;
            for (int i = 0; i < 5; i++) begin
               acc = crc8_step(acc, frame[i]);
               results_due.push_back(tx_result(frame[i], 1'b0));
            end
            results_due.push_back(tx_result(acc, 1'b1));
         end
         OP_READ: begin
            results_due.push_back(tx_result(addr, 1'b0));
            results_due.push_back(tx_result(crc8_step(CRC_INIT, addr), 1'b1));
         end
         OP_REPLY: begin
            if (reply_seen == REPLY_LAST_IDX) begin
               r = '{KIND_DECODE, 8'h00, 1'b0, reply_word, rx == reply_sum};
               results_due.push_back(r);
               reply_seen = 3'd0;
               reply_sum  = CRC_INIT;
               reply_word = 32'h0;
            end else begin
               reply_sum = crc8_step(reply_sum, rx);
               if (reply_seen != 3'd0)
                  reply_word = {reply_word[23:0], rx};
               reply_seen = reply_seen + 3'd1;
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      codec_result_type got;
      codec_result_type want;
      int               before_n;
      if (!reset && req_bus.valid && req_bus.ready) begin
         before_n = results_due.size();
         compute_codec_results(req_bus.opcode, req_bus.reg_address, req_bus.write_value,
                               req_bus.rx_byte);
         if (row_pinned && results_due.size() > before_n)
            results_due[results_due.size() - 1] = row_pin;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.result_kind, rsp_bus.tx_byte, rsp_bus.frame_last,
                 rsp_bus.read_value, rsp_bus.crc_ok};
         if (results_due.size() == 0) begin
            $display("%0t: unexpected transaction: expected none, actual %h", $time, got);
            mismatches++;
         end else begin
            want = results_due.pop_front();
            check_field("result_kind", 32'(want.kind), 32'(got.kind));
            check_field("tx_byte", 32'(want.tx), 32'(got.tx));
            check_field("frame_last", 32'(want.last), 32'(got.last));
            check_field("read_value", want.value, got.value);
            check_field("crc_ok", 32'(want.ok), 32'(got.ok));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL crc8_register_frame_codec_core");
         $finish;
      end
   end

   // Response side: hold ready low for random stalls
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 59) == 0)
               rsp_calm = ~rsp_calm;
            stall_left = draw_gap(rsp_calm);
         end
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [7:0] addr,
                            input logic [31:0] wdata, input logic [7:0] rx,
                            input logic pinned, input codec_result_type pin);
      int unsigned gap;
      if ($urandom_range(0, 39) == 0)
         req_calm = ~req_calm;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.opcode      <= op;
      req_bus.reg_address <= addr;
      req_bus.write_value <= wdata;
      req_bus.rx_byte     <= rx;
      row_pinned          <= pinned;
      row_pin             <= pin;
      do @(posedge clock); while (!req_bus.ready);
      if (op != OP_UNUSED)
         items_sent++;
   endtask

   task automatic send_random(input logic [1:0] op, input logic [7:0] rx);
      send_item(op, 8'($urandom), $urandom, rx, 1'b0, NO_PIN);
   endtask

   // Well-formed reply: address echo, four value bytes, CRC mostly right
   task automatic send_reply_frame();
      logic [7:0] b [6];
      logic [7:0] acc;
      acc = CRC_INIT;
      for (int i = 0; i < 5; i++) begin
         b[i] = 8'($urandom);
         acc  = crc8_step(acc, b[i]);
      end
      b[5] = ($urandom_range(0, 4) == 0) ? (acc ^ (8'h01 << $urandom_range(0, 7))) : acc;
      for (int i = 0; i < 6; i++) begin
         if ($urandom_range(0, 7) == 0)
            send_random($urandom_range(0, 1) == 0 ? OP_WRITE : OP_READ, 8'($urandom));
         send_random(OP_REPLY, b[i]);
      end
   endtask

   initial begin
      int unsigned r;
      reply_seen  = 3'd0;
      reply_sum   = CRC_INIT;
      reply_word  = 32'h0;
      mismatches  = 0;
      items_sent  = 0;
      cycle_count = 0;
      req_calm    = 1'b0;
      rsp_calm    = 1'b0;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.opcode      <= OP_UNUSED;
      req_bus.reg_address <= 8'h00;
      req_bus.write_value <= 32'h0;
      req_bus.rx_byte     <= 8'h00;
      row_pinned          <= 1'b0;
      row_pin             <= NO_PIN;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         send_item(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].wdata,
                   directed_rows[i].rx, directed_rows[i].pinned, directed_rows[i].pin);
      end

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 45)
            send_reply_frame();
         else if (r < 70)
            send_random(OP_WRITE, 8'($urandom));
         else if (r < 85)
            send_random(OP_READ, 8'($urandom));
         else if (r < 93)
            send_random(OP_REPLY, 8'($urandom));
         else
            send_random(OP_UNUSED, 8'($urandom));
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      // drain: catch any stray transaction after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("PASS crc8_register_frame_codec_core");
      else
         $display("FAIL crc8_register_frame_codec_core");
      $finish;
   end

endmodule

`default_nettype wire
